### src/sm3_pkg.sv
// Package: SM3 constants, beat type and round helper functions.
`default_nettype none
package sm3_pkg;

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef logic [31:0] word_t;

  // One classified beat handed from the front part to the back part.
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;   // clamped to 0..4
    logic        last;
  } beat_t;

  function automatic logic [31:0] iv_word(input logic [2:0] k);
    logic [31:0] v;
    begin
      unique case (k)
        3'd0: v = 32'h7380166F;
        3'd1: v = 32'h4914B2B9;
        3'd2: v = 32'h172442D7;
        3'd3: v = 32'hDA8A0600;
        3'd4: v = 32'hA96F30BC;
        3'd5: v = 32'h163138AA;
        3'd6: v = 32'hE38DEE4D;
        default: v = 32'hB0FB0E4E;
      endcase
      return v;
    end
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    begin
      d = {x, x} << n;
      return d[63:32];
    end
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

### src/sm3_stream_if.sv
// Interfaces: input beat channel and digest channel.
`default_nettype none
interface sm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic [2:0]  byte_count;
  logic        last;
  modport source (output valid, word, byte_count, last, input ready);
  modport sink   (input valid, word, byte_count, last, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

### src/sm3_front.sv
// Front part: accepts beats, clamps the byte count, queues them for the back part.
`default_nettype none
module sm3_front (
  input  wire logic    clk,
  input  wire logic    rst,
  sm3_in_if.sink       in_ch,
  output sm3_pkg::beat_t q_beat,
  output logic         q_valid,
  input  wire logic    q_pop
);

  sm3_pkg::beat_t              mem [sm3_pkg::QUEUE_DEPTH];
  logic [sm3_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [sm3_pkg::QPTR_W:0]    used;
  logic                        push;
  sm3_pkg::beat_t              cls;

  assign in_ch.ready = (used != (sm3_pkg::QPTR_W+1)'(sm3_pkg::QUEUE_DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (used != '0);
  assign q_beat = mem[rd_ptr];

  // classify: counts above four mean a full word
  always_comb begin
    cls.data  = in_ch.word;
    cls.count = (in_ch.byte_count > 3'd4) ? 3'd4 : in_ch.byte_count;
    cls.last  = in_ch.last;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      used <= used + (sm3_pkg::QPTR_W+1)'(push) - (sm3_pkg::QPTR_W+1)'(q_pop);
    end
  end

endmodule
`default_nettype wire

### src/sm3_back.sv
// Back part: byte buffering, padding, 64-round compression and digest output.
`default_nettype none
module sm3_back (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire sm3_pkg::beat_t q_beat,
  input  wire logic     q_valid,
  output logic          q_pop,
  sm3_out_if.source     out_ch
);

  localparam logic [2:0] S_TAKE  = 3'd0;  // wait for a queued beat
  localparam logic [2:0] S_BYTE  = 3'd1;  // append bytes one per cycle
  localparam logic [2:0] S_PAD   = 3'd2;  // padding and length bytes
  localparam logic [2:0] S_EXP   = 3'd3;  // load round state
  localparam logic [2:0] S_ROUND = 3'd4;  // one round per cycle
  localparam logic [2:0] S_FOLD  = 3'd5;  // xor into the chaining value
  localparam logic [2:0] S_EMIT  = 3'd6;  // digest beats

  logic [2:0]  state;
  logic [2:0]  ret_state;     // where to go after a compression
  logic [31:0] cv [8];
  logic [31:0] w [16];        // block buffer, then sliding schedule window
  logic [5:0]  fill;
  logic [63:0] total_bits;
  sm3_pkg::beat_t cur;
  logic [2:0]  bidx;          // byte within current beat
  logic [3:0]  pad_idx;       // 0 marker, 1 zeros, length bytes 8..15 below
  logic [5:0]  rnd;
  logic [31:0] ra, rb, rc, rd, re, rf, rg, rh;
  logic [2:0]  emit_idx;
  logic        fin_pending;   // emit after compression

  // byte to be placed this cycle
  logic [7:0]  put;
  logic        put_en;
  logic [3:0]  len_k;

  assign len_k = pad_idx - 4'd8;

  always_comb begin
    put = 8'h00;
    put_en = 1'b0;
    if (state == S_BYTE && bidx < cur.count) begin
      put = cur.data[(5'd24 - {bidx[1:0], 3'b000}) +: 8];
      put_en = 1'b1;
    end else if (state == S_PAD) begin
      put_en = 1'b1;
      if (pad_idx == 4'd0) put = sm3_pkg::PAD_BYTE;
      else if (pad_idx >= 4'd8) put = total_bits[(6'd56 - {len_k[2:0], 3'b000}) +: 8];
    end
  end

  // round datapath
  logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, wnew;
  always_comb begin
    tj  = sm3_pkg::rotl((rnd < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH, rnd[4:0]);
    a12 = sm3_pkg::rotl(ra, 5'd12);
    ss1 = sm3_pkg::rotl(a12 + re + tj, 5'd7);
    ss2 = ss1 ^ a12;
    if (rnd < 6'd16) begin
      ff = ra ^ rb ^ rc;
      gg = re ^ rf ^ rg;
    end else begin
      ff = (ra & rb) | (ra & rc) | (rb & rc);
      gg = (re & rf) | (~re & rg);
    end
    tt1 = ff + rd + ss2 + (w[0] ^ w[4]);
    tt2 = gg + rh + ss1 + w[0];
    wnew = sm3_pkg::p1(w[0] ^ w[7] ^ sm3_pkg::rotl(w[13], 5'd15))
           ^ sm3_pkg::rotl(w[3], 5'd7) ^ w[10];
  end

  assign q_pop = (state == S_TAKE) && q_valid;
  assign out_ch.valid = (state == S_EMIT);
  assign out_ch.digest_word = cv[emit_idx];
  assign out_ch.word_index = emit_idx;
  assign out_ch.last_word = (emit_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_TAKE;
      ret_state <= S_TAKE;
      fill <= '0;
      total_bits <= '0;
      bidx <= '0;
      pad_idx <= '0;
      rnd <= '0;
      emit_idx <= '0;
      fin_pending <= 1'b0;
      for (int k = 0; k < 8; k++) cv[k] <= sm3_pkg::iv_word(3'(k));
    end else begin
      // byte placement shared by the byte and pad states
      if (put_en) begin
        if (fill[1:0] == 2'd0) w[fill[5:2]] <= {put, 24'h0};
        else w[fill[5:2]][(5'd24 - {fill[1:0], 3'b000}) +: 8] <= put;
        fill <= fill + 6'd1;
      end
      unique case (state)
        S_TAKE: begin
          if (q_valid) begin
            cur <= q_beat;
            bidx <= '0;
            state <= S_BYTE;
          end
        end
        S_BYTE: begin
          if (put_en) begin
            bidx <= bidx + 3'd1;
            total_bits <= total_bits + 64'd8;
            if (fill == 6'd63) begin
              ret_state <= S_BYTE;
              state <= S_EXP;
            end
          end else if (cur.last) begin
            pad_idx <= '0;
            state <= S_PAD;
          end else begin
            state <= S_TAKE;
          end
        end
        S_PAD: begin
          // zero fill runs until position 56, then the length bytes;
          // a marker at position 55 goes straight to the length
          if (pad_idx == 4'd0) pad_idx <= (fill == 6'd55) ? 4'd8 : 4'd1;
          else if (pad_idx == 4'd1 && fill == 6'd55) pad_idx <= 4'd8;
          else if (pad_idx >= 4'd8) pad_idx <= pad_idx + 4'd1;
          if (fill == 6'd63) begin
            fin_pending <= (pad_idx == 4'd15);
            ret_state <= S_PAD;
            state <= S_EXP;
          end
        end
        S_EXP: begin
          ra <= cv[0]; rb <= cv[1]; rc <= cv[2]; rd <= cv[3];
          re <= cv[4]; rf <= cv[5]; rg <= cv[6]; rh <= cv[7];
          rnd <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          rd <= rc; rc <= sm3_pkg::rotl(rb, 5'd9); rb <= ra; ra <= tt1;
          rh <= rg; rg <= sm3_pkg::rotl(rf, 5'd19); rf <= re; re <= sm3_pkg::p0(tt2);
          for (int k = 0; k < 15; k++) w[k] <= w[k+1];
          w[15] <= wnew;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          cv[0] <= cv[0] ^ ra; cv[1] <= cv[1] ^ rb;
          cv[2] <= cv[2] ^ rc; cv[3] <= cv[3] ^ rd;
          cv[4] <= cv[4] ^ re; cv[5] <= cv[5] ^ rf;
          cv[6] <= cv[6] ^ rg; cv[7] <= cv[7] ^ rh;
          if (fin_pending) begin
            fin_pending <= 1'b0;
            emit_idx <= '0;
            state <= S_EMIT;
          end else begin
            state <= ret_state;
          end
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              for (int k = 0; k < 8; k++) cv[k] <= sm3_pkg::iv_word(3'(k));
              fill <= '0;
              total_bits <= '0;
              state <= S_TAKE;
            end
          end
        end
        default: state <= S_TAKE;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/sm3_hash_engine_top.sv
// Top level: SM3 hash engine, front queue plus compression back end.
//
//  channel  dir  payload                                  beat taken when
//  in_ch    in   word[32] byte_count[3] last[1]           valid && ready
//  out_ch   out  digest_word[32] word_index[3] last_word  valid && ready
//
// Each beat is taken, its bytes are placed one by one, and it is then closed;
// each full block is compressed by a load step, 64 rounds on the single round
// unit and a fold. Padding places the pad bytes one by one as well.
// Reset is synchronous; the chaining value returns to the IV at once.
// A four-beat queue lets input keep arriving while the back end compresses
// or waits on a stalled digest beat.
`default_nettype none
module sm3_hash_engine_top (
  input  wire logic clk,
  input  wire logic rst,
  sm3_in_if.sink    in_ch,
  sm3_out_if.source out_ch
);

  sm3_pkg::beat_t q_beat;
  logic           q_valid;
  logic           q_pop;

  sm3_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_beat(q_beat), .q_valid(q_valid), .q_pop(q_pop)
  );

  sm3_back u_back (
    .clk(clk), .rst(rst),
    .q_beat(q_beat), .q_valid(q_valid), .q_pop(q_pop), .out_ch(out_ch)
  );

endmodule
`default_nettype wire

### src/sm3_hash_engine_checker.sv
// Checker: port-level properties of the hash engine, bound to the top level.
`default_nettype none
module sm3_hash_engine_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] word_index,
  input wire logic       last_word,
  input wire logic [31:0] digest_word
);

  // last flag marks word seven only
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word mismatch");

  // digest beats count up one by one
  a_seq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && word_index != 3'd7) |=> (out_valid && word_index ==
      $past(word_index) + 3'd1))
    else $error("digest beat order broken");

  // stalled beat holds its data
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(digest_word) && $stable(word_index)))
    else $error("stalled digest beat changed");

  // nothing out straight after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sm3_hash_engine_top sm3_hash_engine_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .word_index(out_ch.word_index), .last_word(out_ch.last_word),
  .digest_word(out_ch.digest_word)
);
`default_nettype wire

### tb/sm3_checker.sv
// Checker: watches both channels, predicts SM3 digests and compares beats.
`timescale 1ns / 100ps
module sm3_checker (
  input  logic      clk,
  input  logic      rst,
  sm3_in_if.sink    in_mon,
  sm3_out_if.sink   out_mon,
  output int        fail_count,
  output int        digests_pending
);

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  localparam logic [31:0] SM3_IV [8] = '{32'h7380166F, 32'h4914B2B9, 32'h172442D7,
    32'hDA8A0600, 32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};
  localparam logic [31:0] ROUND_T_LOW  = 32'h79CC4519;
  localparam logic [31:0] ROUND_T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_MARK     = 8'h80;

  logic [31:0]  chain [8];
  logic [31:0]  blk [16];
  int unsigned  fill;
  logic [63:0]  msg_bits;
  digest_beat_t digest_q[$];

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    n = n % 32;
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  function automatic logic [31:0] mix0(input logic [31:0] x);
    return x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic logic [31:0] mix1(input logic [31:0] x);
    return x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  // 64-round compression of the buffered block into the chaining value
  task automatic compress();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, tt1, tt2, tj;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++)
      w[j] = mix1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? ROUND_T_LOW : ROUND_T_HIGH;
      a12 = rol(a, 12);
      ss1 = rol(a12 + e + rol(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rol(b, 9); b = a; a = tt1;
      h = g; g = rol(f, 19); f = e; e = mix0(tt2);
    end
    chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
    chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
  endtask

  task automatic push_byte(input logic [7:0] v);
    int unsigned idx;
    idx = fill / 4;
    if (fill % 4 == 0) blk[idx] = {v, 24'h0};
    else blk[idx] |= 32'(v) << (24 - 8 * (fill % 4));
    fill++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endtask

  task automatic absorb(input logic [31:0] data, input logic [2:0] cnt, input logic fin);
    int unsigned n;
    digest_beat_t beat;
    n = (cnt > 4) ? 4 : cnt;
    for (int k = 0; k < n; k++) begin
      push_byte(data[31 - 8*k -: 8]);
      msg_bits += 64'd8;
    end
    if (fin) begin
      push_byte(PAD_MARK);
      if (fill > 56) while (fill != 0) push_byte(8'h00);
      while (fill < 56) push_byte(8'h00);
      for (int k = 0; k < 8; k++) push_byte(msg_bits[63 - 8*k -: 8]);
      for (int k = 0; k < 8; k++) begin
        beat.digest_word = chain[k];
        beat.word_index  = 3'(k);
        beat.last_word   = (k == 7);
        digest_q.push_back(beat);
      end
      chain = SM3_IV;
      fill = 0;
      msg_bits = '0;
    end
  endtask

  assign digests_pending = digest_q.size();

  // watch beats on both channels
  always @(posedge clk) begin
    digest_beat_t got, want;
    if (rst) begin
      chain = SM3_IV;
      fill = 0;
      msg_bits = '0;
      digest_q.delete();
      fail_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        absorb(in_mon.word, in_mon.byte_count, in_mon.last);
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.digest_word, out_mon.word_index, out_mon.last_word};
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest beat, actual %h", $time, got);
          fail_count++;
        end else begin
          want = digest_q.pop_front();
          if (got.digest_word !== want.digest_word) begin
            $display("%0t: digest_word expected %h actual %h", $time,
                     want.digest_word, got.digest_word);
            fail_count++;
          end
          if (got.word_index !== want.word_index) begin
            $display("%0t: word_index expected %0d actual %0d", $time,
                     want.word_index, got.word_index);
            fail_count++;
          end
          if (got.last_word !== want.last_word) begin
            $display("%0t: last_word expected %b actual %b", $time,
                     want.last_word, got.last_word);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

### tb/testbench.sv
// Testbench top: clock, reset, stimulus and verdict for the SM3 hash engine.
`timescale 1ns / 100ps
module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   digests_pending;
  int   send_idle_pct = 20;
  int   recv_idle_pct = 61;
  bit   hold_off = 1'b0;

  sm3_in_if  in_ch ();
  sm3_out_if out_ch ();

  sm3_hash_engine_top i_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  sm3_checker i_checker (.clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
                         .fail_count(fail_count), .digests_pending(digests_pending));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // send one beat, with random idle cycles in front of it; valid stays up
  // until the next falling edge, where the next beat or an idle takes over
  task automatic send_beat(input logic [31:0] data, input logic [2:0] cnt, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.word       <= data;
    in_ch.byte_count <= cnt;
    in_ch.last       <= fin;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // a message of n beats, final beat of random size from zero to four bytes
  task automatic send_message(input int n, input bit odd_counts);
    logic [2:0] cnt;
    for (int i = 0; i < n; i++) begin
      cnt = 3'd4;
      if (i == n - 1) cnt = 3'($urandom_range(4));
      else if (odd_counts) cnt = 3'($urandom_range(7));
      send_beat($urandom, cnt, i == n - 1);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (digests_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  initial begin
    int phase_items;
    int n;
    in_ch.valid = 1'b0;
    in_ch.word = '0;
    in_ch.byte_count = '0;
    in_ch.last = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty message, field extremes, oversized counts, padding edges
    send_beat(32'h0, 3'd0, 1'b1);
    send_beat(32'h61626300, 3'd3, 1'b1);
    send_beat(32'hFFFFFFFF, 3'd4, 1'b1);
    send_beat(32'h00000000, 3'd7, 1'b0);
    send_beat(32'hFFFFFFFF, 3'd5, 1'b0);
    send_beat(32'hA5A5A5A5, 3'd6, 1'b1);
    send_beat(32'h12345678, 3'd1, 1'b0);
    send_beat(32'h9ABCDEF0, 3'd2, 1'b0);
    send_beat(32'h0F0F0F0F, 3'd4, 1'b1);
    for (int i = 0; i < 14; i++) send_beat($urandom, 3'd4, i == 13); // 56 bytes
    drain();

    // random messages across three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 61 : 0;
      recv_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 20 : 0;
      phase_items = 0;
      while (phase_items < 48) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 34) : $urandom_range(1, 8);
        send_message(n, $urandom_range(3) == 0);
        phase_items += n;
      end
      drain();
    end

    // long receiver hold-off while messages keep coming in
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 4; i++) send_message(2, 1'b0);
      end
    join
    drain();

    if (fail_count == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #8000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

### sim.f
src/sm3_pkg.sv
src/sm3_stream_if.sv
src/sm3_front.sv
src/sm3_back.sv
src/sm3_hash_engine_top.sv
src/sm3_hash_engine_checker.sv
tb/sm3_checker.sv
tb/testbench.sv
